@@ design/rle8_pkg.sv @@
// Shared types and constants of the BMP RLE8 decoder.
// Standalone package, used by every module of the design.
package rle8_pkg;

  // Row register width and its saturation value
  localparam int unsigned RowW = 11;
  localparam logic [RowW-1:0] RowLimit = '1;

  // Configuration register fields and indexes
  localparam int unsigned CfgW = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegImageWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;
  localparam logic [CfgW-1:0] CfgResetVal = 11'd1024;

  // Escape codes that follow a zero count byte
  localparam logic [7:0] EscEol = 8'd0;
  localparam logic [7:0] EscEob = 8'd1;
  localparam logic [7:0] EscDelta = 8'd2;

  // Output address width
  localparam int unsigned AddrW = 20;

  // Command queue depth
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // Parse phase of the byte stream
  typedef enum logic [2:0] {
    PH_COUNT,
    PH_RUNVAL,
    PH_ESCAPE,
    PH_DELTA_X,
    PH_DELTA_Y,
    PH_ABS,
    PH_PAD,
    PH_DONE
  } phase_e;

  // Work handed from the parser to the executor
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_RUN,
    CMD_EOL,
    CMD_DELTA
  } cmd_op_e;

  // Executor states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREP,
    BK_CHECK,
    BK_SEG
  } back_state_e;

  // One command: run (count, value), delta (dx, dy), end of line or nothing
  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] count;
    logic [7:0] value;
    logic       done;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ design/rle8_front.sv @@
// Byte parser of the RLE8 decoder: tracks the parse phase, one command per byte.
// Depends on rle8_pkg.
module rle8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  output rle8_pkg::cmd_t    cmd_o
);

  rle8_pkg::phase_e phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [7:0] dx_q, dx_d;
  logic [7:0] abs_rem_q, abs_rem_d;
  logic       pad_q, pad_d;

  // Next phase and held fields
  always_comb begin
    phase_d   = phase_q;
    held_d    = held_q;
    dx_d      = dx_q;
    abs_rem_d = abs_rem_q;
    pad_d     = pad_q;
    if (accept_i) begin
      unique case (phase_q)
        rle8_pkg::PH_COUNT: begin
          if (data_byte_i != 8'd0) begin
            held_d  = data_byte_i;
            phase_d = rle8_pkg::PH_RUNVAL;
          end else begin
            phase_d = rle8_pkg::PH_ESCAPE;
          end
        end
        rle8_pkg::PH_RUNVAL: begin
          held_d  = 8'd0;
          phase_d = rle8_pkg::PH_COUNT;
        end
        rle8_pkg::PH_ESCAPE: begin
          priority if (data_byte_i == rle8_pkg::EscEol) begin
            phase_d = rle8_pkg::PH_COUNT;
          end else if (data_byte_i == rle8_pkg::EscEob) begin
            phase_d = rle8_pkg::PH_DONE;
          end else if (data_byte_i == rle8_pkg::EscDelta) begin
            phase_d = rle8_pkg::PH_DELTA_X;
          end else begin
            abs_rem_d = data_byte_i;
            pad_d     = data_byte_i[0];
            phase_d   = rle8_pkg::PH_ABS;
          end
        end
        rle8_pkg::PH_DELTA_X: begin
          dx_d    = data_byte_i;
          phase_d = rle8_pkg::PH_DELTA_Y;
        end
        rle8_pkg::PH_DELTA_Y: begin
          phase_d = rle8_pkg::PH_COUNT;
        end
        rle8_pkg::PH_ABS: begin
          if (abs_rem_q != 8'd0) begin
            abs_rem_d = abs_rem_q - 8'd1;
          end
          if (abs_rem_d == 8'd0) begin
            phase_d = pad_q ? rle8_pkg::PH_PAD : rle8_pkg::PH_COUNT;
          end
        end
        rle8_pkg::PH_PAD: begin
          pad_d   = 1'b0;
          phase_d = rle8_pkg::PH_COUNT;
        end
        rle8_pkg::PH_DONE: begin
          phase_d = rle8_pkg::PH_DONE;
        end
        default: begin
          phase_d = rle8_pkg::PH_COUNT;
        end
      endcase
    end
  end

  // Classify the byte into a command
  always_comb begin
    cmd_o.op    = rle8_pkg::CMD_NOP;
    cmd_o.count = 8'd0;
    cmd_o.value = 8'd0;
    cmd_o.done  = (phase_d == rle8_pkg::PH_DONE);
    unique case (phase_q)
      rle8_pkg::PH_RUNVAL: begin
        cmd_o.op    = rle8_pkg::CMD_RUN;
        cmd_o.count = held_q;
        cmd_o.value = data_byte_i;
      end
      rle8_pkg::PH_ESCAPE: begin
        if (data_byte_i == rle8_pkg::EscEol) begin
          cmd_o.op = rle8_pkg::CMD_EOL;
        end
      end
      rle8_pkg::PH_DELTA_Y: begin
        cmd_o.op    = rle8_pkg::CMD_DELTA;
        cmd_o.count = dx_q;
        cmd_o.value = data_byte_i;
      end
      rle8_pkg::PH_ABS: begin
        cmd_o.op    = rle8_pkg::CMD_RUN;
        cmd_o.count = 8'd1;
        cmd_o.value = data_byte_i;
      end
      default: begin
        cmd_o.op = rle8_pkg::CMD_NOP;
      end
    endcase
  end

  // Phase register and held fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rle8_pkg::PH_COUNT;
      held_q    <= 8'd0;
      dx_q      <= 8'd0;
      abs_rem_q <= 8'd0;
      pad_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      held_q    <= held_d;
      dx_q      <= dx_d;
      abs_rem_q <= abs_rem_d;
      pad_q     <= pad_d;
    end
  end

endmodule

@@ design/rle8_cmdq.sv @@
// Short command queue between the RLE8 parser and the executor.
// Depends on rle8_pkg.
module rle8_cmdq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rle8_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output rle8_pkg::cmd_t     cmd_o,
  output rle8_pkg::q_stat_t  stat_o
);

  rle8_pkg::cmd_t                  entry_q [rle8_pkg::QDepth];
  logic [rle8_pkg::QPtrW-1:0]      wr_ptr_q;
  logic [rle8_pkg::QPtrW-1:0]      rd_ptr_q;
  logic [rle8_pkg::QCntW-1:0]      cnt_q;
  logic                            do_push;
  logic                            do_pop;

  assign stat_o.full  = (cnt_q == rle8_pkg::QCntW'(rle8_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = entry_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ design/rle8_back.sv @@
// Executor of the RLE8 decoder: keeps row and column, splits runs into row
// segments and holds the result register. Depends on rle8_pkg.
module rle8_back #(
  parameter int unsigned WW = 11,
  parameter int unsigned HB = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [WW-1:0]               w_i,
  input  logic [HB-1:0]               h_i,
  input  logic [rle8_pkg::RowW+WW-1:0] hw_i,
  input  rle8_pkg::cmd_t              cmd_i,
  input  rle8_pkg::q_stat_t           q_stat_i,
  output logic                        pop_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        write_valid_o,
  output logic [rle8_pkg::AddrW-1:0]  write_address_o,
  output logic [7:0]                  segment_length_o,
  output logic [7:0]                  pixel_value_o,
  output logic                        last_o,
  output logic                        image_done_o,
  output logic                        out_of_bounds_o
);

  localparam int unsigned RW = rle8_pkg::RowW;
  localparam int unsigned PW = RW + WW;
  localparam int unsigned CW = (WW > 8) ? WW : 8;
  localparam int unsigned DW = CW + 1;

  rle8_pkg::back_state_e state_q, state_d;

  logic [RW-1:0] row_q;
  logic [WW-1:0] col_q;
  logic [7:0]    n_q;
  logic [7:0]    val_q;
  logic          done_q;
  logic          drop_q;
  logic          emitted_q;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] base_q;

  logic          out_valid_q;
  logic          wv_q;
  logic [rle8_pkg::AddrW-1:0] addr_q;
  logic [7:0]    len_q;
  logic [7:0]    pval_q;
  logic          last_q;
  logic          idone_q;
  logic          oob_q;

  logic          slot_free;
  logic          wrap;
  logic [RW-1:0] row_inc;
  logic [RW-1:0] row0;
  logic [WW-1:0] col0;
  logic [PW-1:0] base0;
  logic [CW-1:0] room;
  logic [7:0]    take;
  logic          in_frame;
  logic          seg_final;
  logic          next_out;
  logic [PW:0]   span_end;
  logic [DW-1:0] col_sum;
  logic [RW:0]   row_sum;
  logic [RW-1:0] row_delta;
  logic [WW-1:0] col_delta;

  // Result strobes
  logic          emit;
  logic          e_wv;
  logic [rle8_pkg::AddrW-1:0] e_addr;
  logic [7:0]    e_len;
  logic [7:0]    e_val;
  logic          e_last;
  logic          e_done;
  logic          e_oob;
  logic          seg_step;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Row wrap at row end and segment size
  always_comb begin
    wrap    = (col_q >= w_i);
    row_inc = (row_q == rle8_pkg::RowLimit) ? row_q : row_q + 1'b1;
    row0    = wrap ? row_inc : row_q;
    col0    = wrap ? '0 : col_q;
    base0   = wrap ? base_q - PW'(w_i) : base_q;
    room    = CW'(w_i) - CW'(col0);
    take    = (room > CW'(n_q)) ? n_q : 8'(room);
    in_frame  = (row0 < RW'(h_i));
    seg_final = (n_q == take);
    next_out  = ((RW+1)'(row0) + 1'b1) >= (RW+1)'(h_i);
    span_end  = (PW+1)'(prod_q) + (PW+1)'(col_q) + (PW+1)'(n_q);
  end

  // Delta move with column and row saturation
  always_comb begin
    col_sum   = DW'(col_q) + DW'(cmd_i.count);
    col_delta = (col_sum > DW'(w_i)) ? w_i : WW'(col_sum);
    row_sum   = (RW+1)'(row_q) + (RW+1)'(cmd_i.value);
    row_delta = (row_sum > (RW+1)'(rle8_pkg::RowLimit)) ? rle8_pkg::RowLimit : RW'(row_sum);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rle8_pkg::BK_IDLE: begin
        if (!q_stat_i.empty && cmd_i.op == rle8_pkg::CMD_RUN) begin
          state_d = rle8_pkg::BK_PREP;
        end
      end
      rle8_pkg::BK_PREP: begin
        state_d = rle8_pkg::BK_CHECK;
      end
      rle8_pkg::BK_CHECK: begin
        state_d = rle8_pkg::BK_SEG;
      end
      rle8_pkg::BK_SEG: begin
        if (slot_free && seg_final) begin
          state_d = rle8_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = rle8_pkg::BK_IDLE;
      end
    endcase
  end

  // Pop and result strobes
  always_comb begin
    pop_o    = 1'b0;
    emit     = 1'b0;
    seg_step = 1'b0;
    e_wv     = 1'b0;
    e_addr   = '0;
    e_len    = 8'd0;
    e_val    = 8'd0;
    e_last   = 1'b1;
    e_done   = 1'b0;
    e_oob    = 1'b0;
    unique case (state_q)
      rle8_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          if (cmd_i.op == rle8_pkg::CMD_RUN) begin
            pop_o = 1'b1;
          end else if (slot_free) begin
            pop_o  = 1'b1;
            emit   = 1'b1;
            e_done = cmd_i.done;
          end
        end
      end
      rle8_pkg::BK_SEG: begin
        if (slot_free) begin
          seg_step = 1'b1;
          e_oob    = drop_q;
          e_done   = done_q;
          if (in_frame) begin
            emit   = 1'b1;
            e_wv   = 1'b1;
            e_addr = rle8_pkg::AddrW'((PW+1)'(base0) + (PW+1)'(col0));
            e_len  = take;
            e_val  = val_q;
            e_last = seg_final || next_out;
          end else if (seg_final && !emitted_q) begin
            emit = 1'b1;
          end
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // Position, run and executor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rle8_pkg::BK_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      n_q       <= 8'd0;
      emitted_q <= 1'b0;
      drop_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        rle8_pkg::BK_IDLE: begin
          if (pop_o) begin
            unique case (cmd_i.op)
              rle8_pkg::CMD_RUN: begin
                n_q    <= cmd_i.count;
                done_q <= cmd_i.done;
              end
              rle8_pkg::CMD_EOL: begin
                col_q <= '0;
                row_q <= row_inc;
              end
              rle8_pkg::CMD_DELTA: begin
                col_q <= col_delta;
                row_q <= row_delta;
              end
              default: begin
                done_q <= done_q;
              end
            endcase
          end
        end
        rle8_pkg::BK_PREP: begin
          row_q <= row0;
          col_q <= col0;
        end
        rle8_pkg::BK_CHECK: begin
          drop_q    <= (span_end > (PW+1)'(hw_i));
          emitted_q <= 1'b0;
        end
        rle8_pkg::BK_SEG: begin
          if (seg_step) begin
            row_q     <= row0;
            col_q     <= WW'(CW'(col0) + CW'(take));
            n_q       <= n_q - take;
            emitted_q <= emitted_q || in_frame;
          end
        end
        default: begin
          n_q <= n_q;
        end
      endcase
    end
  end

  // Run payload, product and row base
  always_ff @(posedge clk_i) begin
    if (state_q == rle8_pkg::BK_IDLE && pop_o) begin
      val_q <= cmd_i.value;
    end
    if (state_q == rle8_pkg::BK_PREP) begin
      prod_q <= PW'(row0) * PW'(w_i);
    end
    if (state_q == rle8_pkg::BK_CHECK) begin
      base_q <= hw_i - PW'(w_i) - prod_q;
    end else if (seg_step) begin
      base_q <= base0;
    end
  end

  // Result register: load on emit, drop valid once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      wv_q    <= e_wv;
      addr_q  <= e_addr;
      len_q   <= e_len;
      pval_q  <= e_val;
      last_q  <= e_last;
      idone_q <= e_done;
      oob_q   <= e_oob;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign write_valid_o    = wv_q;
  assign write_address_o  = addr_q;
  assign segment_length_o = len_q;
  assign pixel_value_o    = pval_q;
  assign last_o           = last_q;
  assign image_done_o     = idone_q;
  assign out_of_bounds_o  = oob_q;

endmodule

@@ design/bmp_rle8_decoder.sv @@
// BMP RLE8 decoder, top level. A byte that writes nothing passes the command queue and
// the result register; a run byte passes the queue, the executor states PREP, CHECK and
// SEG, and the result register, with one SEG step per row segment, rows above the image
// included. The queue takes new bytes while the executor works on a run, until full.
// Reset: parse at count byte, row and column zero, queue empty, width and height 1024.
// Depends on rle8_pkg, rle8_front, rle8_cmdq and rle8_back.
module bmp_rle8_decoder #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               write_valid_o,
  output logic [rle8_pkg::AddrW-1:0]         write_address_o,
  output logic [7:0]                         segment_length_o,
  output logic [7:0]                         pixel_value_o,
  output logic                               last_o,
  output logic                               image_done_o,
  output logic                               out_of_bounds_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rle8_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rle8_pkg::CfgW-1:0]          cfg_data_i
);

  localparam int unsigned WRaw = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HRaw = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WW = (WRaw > rle8_pkg::CfgW) ? rle8_pkg::CfgW : WRaw;
  localparam int unsigned HB = (HRaw > rle8_pkg::CfgW) ? rle8_pkg::CfgW : HRaw;
  localparam int unsigned PW = rle8_pkg::RowW + WW;

  logic [rle8_pkg::CfgW-1:0] width_cfg_q;
  logic [rle8_pkg::CfgW-1:0] height_cfg_q;
  logic [WW-1:0]             w_eff;
  logic [HB-1:0]             h_eff;
  logic [PW-1:0]             hw_q;

  logic                      in_accept;
  rle8_pkg::cmd_t            front_cmd;
  rle8_pkg::cmd_t            q_cmd;
  rle8_pkg::q_stat_t         q_stat;
  logic                      q_pop;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= rle8_pkg::CfgResetVal;
      height_cfg_q <= rle8_pkg::CfgResetVal;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == rle8_pkg::RegImageWidth) begin
        width_cfg_q <= cfg_data_i;
      end else if (cfg_index_i == rle8_pkg::RegImageHeight) begin
        height_cfg_q <= cfg_data_i;
      end
    end
  end

  // Clamp width to [8, MAX_WIDTH] and height to [1, MAX_HEIGHT]
  always_comb begin
    priority if (int'(width_cfg_q) > int'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (int'(width_cfg_q) < 8) begin
      w_eff = WW'(8);
    end else begin
      w_eff = WW'(width_cfg_q);
    end
    priority if (int'(height_cfg_q) > int'(MAX_HEIGHT)) begin
      h_eff = HB'(MAX_HEIGHT);
    end else if (height_cfg_q == '0) begin
      h_eff = HB'(1);
    end else begin
      h_eff = HB'(height_cfg_q);
    end
  end

  // Image size in pixels, used by the drop check
  always_ff @(posedge clk_i) begin
    hw_q <= PW'(h_eff) * PW'(w_eff);
  end

  // Byte transfer into the parser while the queue has room
  assign in_stall_o = q_stat.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  rle8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .cmd_o       (front_cmd)
  );

  rle8_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_accept),
    .cmd_i  (front_cmd),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd),
    .stat_o (q_stat)
  );

  rle8_back #(
    .WW (WW),
    .HB (HB)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .w_i              (w_eff),
    .h_i              (h_eff),
    .hw_i             (hw_q),
    .cmd_i            (q_cmd),
    .q_stat_i         (q_stat),
    .pop_o            (q_pop),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .write_valid_o    (write_valid_o),
    .write_address_o  (write_address_o),
    .segment_length_o (segment_length_o),
    .pixel_value_o    (pixel_value_o),
    .last_o           (last_o),
    .image_done_o     (image_done_o),
    .out_of_bounds_o  (out_of_bounds_o)
  );

  // A write segment never has zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> segment_length_o != 8'd0)
    else $error("write segment with zero length");

  // A result without a write always closes its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> last_o)
    else $error("non-write result not marked last");

  // No pixel writes once the bitmap has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> !image_done_o)
    else $error("pixel write after end of bitmap");

  // Queue status is never full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !q_stat.empty)
    else $error("command queue status inconsistent");

endmodule
